### sv/crcac_pkg.sv
// ----------------------------------------------------------------------------
// crcac_pkg: shared types and constants of the CRC append and check block
// Polynomial selector codes, polynomial and width tables, register
// indexes and the result item carried through the output queue.
// ----------------------------------------------------------------------------
package crcac_pkg;

    localparam int unsigned POLY_W = 24;   // widest polynomial in the set
    localparam int unsigned LEN_W  = 5;    // holds a CRC length up to 24
    localparam int unsigned SEL_W  = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 3;

    localparam logic [SEL_W-1:0] SEL_NONE   = 3'd0;
    localparam logic [SEL_W-1:0] SEL_CRC3   = 3'd1;
    localparam logic [SEL_W-1:0] SEL_CRC6   = 3'd2;
    localparam logic [SEL_W-1:0] SEL_CRC11  = 3'd3;
    localparam logic [SEL_W-1:0] SEL_CRC16  = 3'd4;
    localparam logic [SEL_W-1:0] SEL_CRC24C = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_CRC_SELECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_MODE = 2'd1;

    typedef struct packed {
        logic out_bit;
        logic is_parity;
        logic crc_fail;
        logic run_last;
    } t_result;

    // Broadcast to every cell of the remainder chain.
    typedef struct packed {
        logic             adv;    // take the next value this cycle
        logic             clear;  // frame end: drop the remainder
        logic             fb;     // feedback into the polynomial taps
        logic [LEN_W-1:0] len;    // cells at or above len read as zero
    } t_cell_ctl;

    function automatic logic [POLY_W-1:0] poly_of(input logic [SEL_W-1:0] sel);
        logic [POLY_W-1:0] p;
        case (sel)
            SEL_CRC3:   p = 24'h000003;
            SEL_CRC6:   p = 24'h000021;
            SEL_CRC11:  p = 24'h000621;
            SEL_CRC16:  p = 24'h001021;
            SEL_CRC24C: p = 24'hB2B117;
            default:    p = 24'h000000;
        endcase
        return p;
    endfunction

    function automatic logic [LEN_W-1:0] len_of(input logic [SEL_W-1:0] sel);
        logic [LEN_W-1:0] l;
        case (sel)
            SEL_CRC3:   l = 5'd3;
            SEL_CRC6:   l = 5'd6;
            SEL_CRC11:  l = 5'd11;
            SEL_CRC16:  l = 5'd16;
            SEL_CRC24C: l = 5'd24;
            default:    l = 5'd0;
        endcase
        return l;
    endfunction

endpackage

### sv/crcac_cell.sv
// ----------------------------------------------------------------------------
// crcac_cell: one bit of the CRC remainder chain
// Takes the bit of its lower neighbor, xors in the feedback where the
// polynomial has a tap, and reads as zero above the selected length.
// ----------------------------------------------------------------------------
module crcac_cell #(
    parameter int INDEX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  crcac_pkg::t_cell_ctl i_ctl,
    input  logic                 i_tap,
    input  logic                 i_lower,
    output logic                 o_bit,
    output logic                 o_step
);

    logic r_bit;
    logic n_bit;

    assign o_step = (int'(i_ctl.len) > INDEX) ? (i_lower ^ (i_ctl.fb & i_tap)) : 1'b0;

    always_comb begin
        n_bit = r_bit;
        if (i_ctl.adv) begin
            n_bit = i_ctl.clear ? 1'b0 : o_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

### sv/crcac_out_fifo.sv
// ----------------------------------------------------------------------------
// crcac_out_fifo: two-entry result queue
// Parts the result stream from the downstream stall; full is registered.
// ----------------------------------------------------------------------------
module crcac_out_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  crcac_pkg::t_result i_data,
    input  logic               i_pop_stall,
    output logic               o_valid,
    output crcac_pkg::t_result o_data,
    output logic               o_full
);

    crcac_pkg::t_result r_mem [2];
    logic               r_wr;
    logic               r_rd;
    logic [1:0]         r_cnt;
    logic               pop;
    logic [1:0]         n_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid & ~i_pop_stall;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### sv/crc_append_and_check.sv
// ----------------------------------------------------------------------------
// crc_append_and_check: bit-serial CRC encoder and checker
// Remainder held in a chain of one-bit cells; results leave through a
// two-entry queue.
// ----------------------------------------------------------------------------
// One input item is taken per cycle unless the input is stalled. In encode
// mode a frame-ending item with a CRC selected is followed by L parity
// results (L = 3, 6, 11, 16 or 24), during which the parity sequencer
// shifts the remainder chain out MSB first and the input is stalled.
// Results pass through a two-entry output queue, so the input stall comes
// from the registered queue-full flag and the parity tail, not from the
// downstream stall. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module crc_append_and_check #(
    parameter int MAX_CRC_WIDTH = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [crcac_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [crcac_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_data_bit,
    input  logic                             i_frame_last,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_out_bit,
    output logic                             o_is_parity,
    output logic                             o_crc_fail,
    output logic                             o_run_last
);

    localparam int CNT_W = $clog2(MAX_CRC_WIDTH + 1);

    logic [crcac_pkg::SEL_W-1:0] r_sel;
    logic                        r_check;
    logic [CNT_W-1:0]            r_tail_cnt;

    logic [crcac_pkg::LEN_W-1:0] len;
    logic [MAX_CRC_WIDTH-1:0]    poly;
    logic [MAX_CRC_WIDTH-1:0]    rem;
    logic [MAX_CRC_WIDTH-1:0]    step;
    logic                        msb;
    logic                        tail_active;
    logic                        tail_push;
    logic                        accept;
    logic                        full;
    logic                        push;
    crcac_pkg::t_cell_ctl        ctl;
    crcac_pkg::t_result          res;
    crcac_pkg::t_result          head;

    assign len  = crcac_pkg::len_of(r_sel);
    assign poly = MAX_CRC_WIDTH'(crcac_pkg::poly_of(r_sel));

    always_comb begin
        msb = 1'b0;
        for (int i = 0; i < MAX_CRC_WIDTH; i++) begin
            if (i + 1 == int'(len)) begin
                msb = rem[i];
            end
        end
    end

    assign tail_active = (r_tail_cnt != '0);
    assign tail_push   = tail_active & ~full;
    assign o_in_stall  = full | tail_active;
    assign accept      = i_in_valid & ~o_in_stall;
    assign push        = accept | tail_push;

    always_comb begin
        ctl.adv   = push;
        ctl.len   = len;
        ctl.clear = accept & i_frame_last & (r_check | (len == '0));
        // Parity tail shifts with no feedback.
        if (tail_active) begin
            ctl.fb = 1'b0;
        end else if (r_check) begin
            ctl.fb = msb;
        end else begin
            ctl.fb = msb ^ i_data_bit;
        end
    end

    for (genvar g = 0; g < MAX_CRC_WIDTH; g++) begin : g_cell
        logic lower;
        if (g == 0) begin : g_bottom
            assign lower = r_check & i_data_bit & ~tail_active;
        end else begin : g_link
            assign lower = rem[g-1];
        end
        crcac_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_tap   (poly[g]),
            .i_lower (lower),
            .o_bit   (rem[g]),
            .o_step  (step[g])
        );
    end

    always_comb begin
        if (tail_active) begin
            res.out_bit   = msb;
            res.is_parity = 1'b1;
            res.crc_fail  = 1'b0;
            res.run_last  = (r_tail_cnt == CNT_W'(1));
        end else if (r_check) begin
            res.out_bit   = 1'b0;
            res.is_parity = 1'b0;
            res.crc_fail  = i_frame_last & (|step);
            res.run_last  = 1'b1;
        end else begin
            res.out_bit   = i_data_bit;
            res.is_parity = 1'b0;
            res.crc_fail  = 1'b0;
            res.run_last  = ~(i_frame_last & (len != '0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel      <= crcac_pkg::SEL_NONE;
            r_check    <= 1'b0;
            r_tail_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    crcac_pkg::CFG_CRC_SELECT: r_sel   <= i_cfg_data;
                    crcac_pkg::CFG_CHECK_MODE: r_check <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // Start the parity tail on an encoded frame end.
            if (accept && i_frame_last && !r_check) begin
                r_tail_cnt <= CNT_W'(len);
            end else if (tail_push) begin
                r_tail_cnt <= r_tail_cnt - CNT_W'(1);
            end
        end
    end

    crcac_out_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      (res),
        .i_pop_stall (i_out_stall),
        .o_valid     (o_out_valid),
        .o_data      (head),
        .o_full      (full)
    );

    assign o_out_bit   = head.out_bit;
    assign o_is_parity = head.is_parity;
    assign o_crc_fail  = head.crc_fail;
    assign o_run_last  = head.run_last;

endmodule

### sv/crcac_checker.sv
// ----------------------------------------------------------------------------
// crcac_checker: port-level assertions for crc_append_and_check
// Watches the handshakes and result fields seen at the top-level ports.
// ----------------------------------------------------------------------------
module crcac_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_out_bit,
    input logic o_is_parity,
    input logic o_crc_fail,
    input logic o_run_last
);

    // Queue comes up empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // An accepted item always leaves something queued.
    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted item left no result");

    // A failure flag only rides on a lone check result.
    a_fail_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_crc_fail) |-> (o_run_last && !o_is_parity && !o_out_bit))
        else $error("crc failure on a malformed result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_bit)
            && $stable(o_is_parity) && $stable(o_crc_fail) && $stable(o_run_last)))
        else $error("stalled result changed");

endmodule

bind crc_append_and_check crcac_checker u_crcac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_bit   (o_out_bit),
    .o_is_parity (o_is_parity),
    .o_crc_fail  (o_crc_fail),
    .o_run_last  (o_run_last)
);
